@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants, action codes and cell control type for the deque
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CAPACITY   = 256;
  localparam int WORD_WIDTH = 32;

  // stored word width, limited by the 32-bit value field
  localparam int STORE_W  = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TREE_LVL = $clog2(CAPACITY);
  localparam int TREE_NP  = 1 << TREE_LVL;
  localparam int SETTLE_W = $clog2(TREE_LVL + 1);

  localparam int ACTION_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int OCC_W     = 9;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_QUERY      = 3'd5
  } deq_action_t;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } deq_op_t;

endpackage

@@ rtl/core/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// fixed-capacity deque of words held in a shifting chain of cells
// ----------------------------------------------------------------------------
// The words sit in a row of CAPACITY cells with the front word always in the
// first cell: a push or pop at the front shifts the whole row by one place,
// a push or pop at the back touches only the cell at the end of the occupied
// run. The back word is gathered by a registered or-tree of log2(CAPACITY)
// levels, and a transaction is not accepted until the previous one has settled
// through the tree and been posted in an output register; the next
// transaction is taken while the result waits there.
// A push on a full queue and a pop on an empty one are refused; clear always
// succeeds; unknown actions act as query. Front and back read zero when empty.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // action[2:0], value[34:3], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // accepted[0], front_value[32:1],
                                            // back_value[64:33], occupancy[73:65],
                                            // is_empty[74], zero pad
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SETTLE = 2'b10
  } deq_state_t;

  deq_state_t state_r, state_nxt;
  logic [SETTLE_W-1:0]   settle_r, settle_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [ACTION_W-1:0] action;
  logic [STORE_W-1:0]  push_word;
  logic                in_fire, load, full, empty, ok;
  deq_op_t             op;

  logic [STORE_W-1:0]               cell_word  [CAPACITY];
  logic                             cell_valid [CAPACITY];
  logic [CAPACITY-1:0][STORE_W-1:0] leaf_word;
  logic [STORE_W-1:0]               back_word;
  logic [VALUE_W-1:0]               front_out, back_out;

  assign action    = in_tdata[ACTION_W-1:0];
  assign push_word = in_tdata[ACTION_W +: STORE_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);

  always_comb begin
    ok = 1'b1;
    case (action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: ok = !full;
      ACT_POP_FRONT, ACT_POP_BACK:   ok = !empty;
      default:                       ok = 1'b1;
    endcase
  end

  always_comb begin
    op        = '0;
    count_nxt = count_r;
    if (in_fire && ok) begin
      case (action)
        ACT_PUSH_FRONT: begin
          op.push_front = 1'b1;
          count_nxt     = count_r + 1'b1;
        end
        ACT_PUSH_BACK: begin
          op.push_back = 1'b1;
          count_nxt    = count_r + 1'b1;
        end
        ACT_POP_FRONT: begin
          op.pop_front = 1'b1;
          count_nxt    = count_r - 1'b1;
        end
        ACT_POP_BACK: begin
          op.pop_back = 1'b1;
          count_nxt   = count_r - 1'b1;
        end
        ACT_CLEAR: begin
          op.clear  = 1'b1;
          count_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [STORE_W-1:0] lw, rw;
      logic               lv, rv;
      if (i == 0) begin : g_first
        assign lw = push_word;
        assign lv = 1'b1;
      end else begin : g_mid_l
        assign lw = cell_word[i-1];
        assign lv = cell_valid[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rw = '0;
        assign rv = 1'b0;
      end else begin : g_mid_r
        assign rw = cell_word[i+1];
        assign rv = cell_valid[i+1];
      end

      deq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .push_word   (push_word),
        .left_word   (lw),
        .left_valid  (lv),
        .right_word  (rw),
        .right_valid (rv),
        .cell_word   (cell_word[i]),
        .cell_valid  (cell_valid[i])
      );

      assign leaf_word[i] = (cell_valid[i] && !rv) ? cell_word[i] : '0;
    end
  endgenerate

  deq_back_tree u_back_tree (
    .clk       (clk),
    .leaf_word (leaf_word),
    .back_word (back_word)
  );

  assign front_out = cell_valid[0] ? VALUE_W'(cell_word[0]) : '0;
  assign back_out  = VALUE_W'(back_word);
  assign load      = (state_r == ST_SETTLE) && (settle_r == '0)
                     && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    settle_nxt    = settle_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt    = ok;
          settle_nxt = SETTLE_W'(TREE_LVL);
          state_nxt  = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (settle_r != '0) begin
          settle_nxt = settle_r - 1'b1;
        end else if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, empty, OCC_W'(count_r), back_out, front_out, acc_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      settle_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      settle_r    <= settle_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/core/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// one word slot of the deque chain, shifting with its neighbours
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  deq_op_t            op,
  input  logic [STORE_W-1:0] push_word,
  input  logic [STORE_W-1:0] left_word,
  input  logic               left_valid,
  input  logic [STORE_W-1:0] right_word,
  input  logic               right_valid,
  output logic [STORE_W-1:0] cell_word,
  output logic               cell_valid
);

  logic [STORE_W-1:0] word_r, word_nxt;
  logic               valid_r, valid_nxt;

  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    if (op.clear) begin
      valid_nxt = 1'b0;
    end else if (op.push_front) begin
      word_nxt  = left_word;
      valid_nxt = left_valid;
    end else if (op.pop_front) begin
      word_nxt  = right_word;
      valid_nxt = right_valid;
    end else if (op.push_back && !valid_r && left_valid) begin
      word_nxt  = push_word;
      valid_nxt = 1'b1;
    end else if (op.pop_back && valid_r && !right_valid) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign cell_word  = word_r;
  assign cell_valid = valid_r;

endmodule

@@ rtl/core/deq_back_tree.sv @@
// ----------------------------------------------------------------------------
// deq_back_tree
// registered or-tree picking the word of the last occupied cell
// ----------------------------------------------------------------------------
module deq_back_tree
  import deq_pkg::*;
(
  input  logic                              clk,
  input  logic [CAPACITY-1:0][STORE_W-1:0] leaf_word,
  output logic [STORE_W-1:0]               back_word
);

  logic [STORE_W-1:0] node_r [TREE_NP-1];
  logic [STORE_W-1:0] leaf   [TREE_NP];

  genvar i;
  generate
    for (i = 0; i < TREE_NP; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_used
        assign leaf[i] = leaf_word[i];
      end else begin : g_pad
        assign leaf[i] = '0;
      end
    end

    for (i = 0; i < TREE_NP - 1; i++) begin : g_node
      logic [STORE_W-1:0] lhs, rhs;
      if (2 * i + 1 >= TREE_NP - 1) begin : g_from_leaf
        assign lhs = leaf[2 * i + 1 - (TREE_NP - 1)];
        assign rhs = leaf[2 * i + 2 - (TREE_NP - 1)];
      end else begin : g_from_node
        assign lhs = node_r[2 * i + 1];
        assign rhs = node_r[2 * i + 2];
      end
      always_ff @(posedge clk) begin
        node_r[i] <= lhs | rhs;
      end
    end
  endgenerate

  assign back_word = node_r[0];

endmodule

@@ rtl/core/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks on the deque result stream
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [OCC_W-1:0] occ;
  logic             is_empty;

  assign occ      = out_tdata[73:65];
  assign is_empty = out_tdata[74];

  a_empty_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (is_empty == (occ == '0)))
    else $error("empty flag disagrees with occupancy");

  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && is_empty) |-> (out_tdata[64:1] == '0))
    else $error("front or back word not zero on empty queue");

  a_occ_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CAPACITY > 511 || 32'(occ) <= CAPACITY))
    else $error("occupancy beyond capacity");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
